@@ design/ipr_pkg.sv @@
package ipr_pkg;

    // replication and coordinate limits
    localparam int MAX_FACTOR = 8;
    localparam int COORD_BITS = 12;

    // field widths
    localparam int PIX_W   = 8;
    localparam int ORG_W   = 12;
    localparam int DIM_W   = 13;
    localparam int PITCH_W = 16;
    localparam int SCALE_W = 4;
    localparam int ADDR_W  = 30;
    localparam int DATA_W  = 32;

    // derived widths
    localparam int FACTOR_W = $clog2(MAX_FACTOR + 1);
    localparam int SUM_W    = ((ORG_W > COORD_BITS) ? ORG_W : COORD_BITS) + 1;
    localparam int EXT_W    = (DIM_W > COORD_BITS + 1) ? DIM_W : COORD_BITS + 1;
    localparam int XB_W     = SUM_W + FACTOR_W;
    localparam int LINE_W   = SUM_W + FACTOR_W;
    localparam int PROD_W   = LINE_W + PITCH_W;

    // request queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // register map
    localparam int NUM_REGS  = 6;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int PADDR_W   = REG_IDX_W + 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ORIGIN_X     = 3'd0,
        REG_ORIGIN_Y     = 3'd1,
        REG_RECT_WIDTH   = 3'd2,
        REG_RECT_HEIGHT  = 3'd3,
        REG_DEST_PITCH   = 3'd4,
        REG_SCALE_FACTOR = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [ORG_W-1:0]   origin_x;
        logic [ORG_W-1:0]   origin_y;
        logic [DIM_W-1:0]   rect_width;
        logic [DIM_W-1:0]   rect_height;
        logic [PITCH_W-1:0] dest_pitch;
        logic [SCALE_W-1:0] scale_factor;
    } t_cfg;

    // one classified pixel waiting for its writes
    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic [ADDR_W-1:0] row_base;
        logic [XB_W-1:0]   xbase;
        logic              last_pix;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // factor zero acts as one, above the limit acts as the limit
    function automatic logic [FACTOR_W-1:0] eff_factor(input logic [SCALE_W-1:0] s);
        logic [FACTOR_W-1:0] f;
        if (s == '0) begin
            f = FACTOR_W'(1);
        end else if (s > MAX_FACTOR) begin
            f = FACTOR_W'(MAX_FACTOR);
        end else begin
            f = FACTOR_W'(s);
        end
        return f;
    endfunction

    // extent zero acts as one, clamped to the coordinate range
    function automatic logic [EXT_W-1:0] eff_extent(input logic [DIM_W-1:0] v);
        logic [EXT_W-1:0] e;
        logic [EXT_W-1:0] lim;
        e   = EXT_W'(v);
        lim = EXT_W'(1) << COORD_BITS;
        if (e == '0) begin
            e = EXT_W'(1);
        end else if (e > lim) begin
            e = lim;
        end
        return e;
    endfunction

endpackage

@@ design/ipr_if.sv @@
interface ipr_in_if;
    logic                         valid;
    logic                         ready;
    logic [ipr_pkg::PIX_W-1:0]    pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface ipr_out_if;
    logic                         valid;
    logic                         ready;
    logic [ipr_pkg::ADDR_W-1:0]   write_address;
    logic [ipr_pkg::PIX_W-1:0]    write_value;
    logic                         block_last;
    logic                         rect_done;

    modport source (output valid, output write_address, output write_value,
                    output block_last, output rect_done, input ready);
    modport sink   (input valid, input write_address, input write_value,
                    input block_last, input rect_done, output ready);
endinterface

@@ design/integer_pixel_replication_scaler.sv @@
// integer pixel replication scaler
// i_pix carries 8-bit source pixels of a rectangle in raster order (valid/ready).
// o_wr carries factor x factor writes per pixel: byte address, value, a flag on
// the last write of each pixel and a flag on the last write of the rectangle.
// the apb port sets origin, rectangle size, destination pitch and factor;
// any write to a register restarts the rectangle at its first pixel.
// a pixel's request passes the classification stage, the queue and the output
// register before its first write is valid.
// the back-end sequencer issues one write per cycle while the queue holds a
// request and the receiver is ready, and each pixel takes factor squared writes.
// a four-entry queue separates the front (counters, address multiply) from
// the back, so pixels keep being accepted while earlier writes drain.
// when the receiver stalls, the output register holds its write, the queue
// fills and then i_pix.ready drops.
// reset clears counters, queue and output valid and loads register defaults;
// there is no clearing pass.
module integer_pixel_replication_scaler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ipr_in_if.sink                        i_pix,
    ipr_out_if.source                     o_wr,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ipr_pkg::PADDR_W-1:0]   paddr,
    input  logic [ipr_pkg::DATA_W-1:0]    pwdata,
    output logic [ipr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    ipr_pkg::t_cfg     r_cfg;
    ipr_pkg::t_reg_idx idx;
    logic              wr;
    logic              restart;
    logic              push;
    logic              pop;
    ipr_pkg::t_entry   push_entry;
    ipr_pkg::t_entry   head;
    ipr_pkg::t_q_stat  q_stat;

    // register decode
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign idx    = ipr_pkg::t_reg_idx'(paddr[ipr_pkg::PADDR_W-1:2]);

    always_comb begin
        restart = 1'b0;
        unique case (idx)
            ipr_pkg::REG_ORIGIN_X,
            ipr_pkg::REG_ORIGIN_Y,
            ipr_pkg::REG_RECT_WIDTH,
            ipr_pkg::REG_RECT_HEIGHT,
            ipr_pkg::REG_DEST_PITCH,
            ipr_pkg::REG_SCALE_FACTOR: restart = wr;
            default: restart = 1'b0;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x     <= '0;
            r_cfg.origin_y     <= '0;
            r_cfg.rect_width   <= ipr_pkg::DIM_W'(1);
            r_cfg.rect_height  <= ipr_pkg::DIM_W'(1);
            r_cfg.dest_pitch   <= ipr_pkg::PITCH_W'(1);
            r_cfg.scale_factor <= ipr_pkg::SCALE_W'(2);
        end else if (wr) begin
            unique case (idx)
                ipr_pkg::REG_ORIGIN_X:     r_cfg.origin_x     <= pwdata[ipr_pkg::ORG_W-1:0];
                ipr_pkg::REG_ORIGIN_Y:     r_cfg.origin_y     <= pwdata[ipr_pkg::ORG_W-1:0];
                ipr_pkg::REG_RECT_WIDTH:   r_cfg.rect_width   <= pwdata[ipr_pkg::DIM_W-1:0];
                ipr_pkg::REG_RECT_HEIGHT:  r_cfg.rect_height  <= pwdata[ipr_pkg::DIM_W-1:0];
                ipr_pkg::REG_DEST_PITCH:   r_cfg.dest_pitch   <= pwdata[ipr_pkg::PITCH_W-1:0];
                ipr_pkg::REG_SCALE_FACTOR: r_cfg.scale_factor <= pwdata[ipr_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (idx)
            ipr_pkg::REG_ORIGIN_X:     prdata = ipr_pkg::DATA_W'(r_cfg.origin_x);
            ipr_pkg::REG_ORIGIN_Y:     prdata = ipr_pkg::DATA_W'(r_cfg.origin_y);
            ipr_pkg::REG_RECT_WIDTH:   prdata = ipr_pkg::DATA_W'(r_cfg.rect_width);
            ipr_pkg::REG_RECT_HEIGHT:  prdata = ipr_pkg::DATA_W'(r_cfg.rect_height);
            ipr_pkg::REG_DEST_PITCH:   prdata = ipr_pkg::DATA_W'(r_cfg.dest_pitch);
            ipr_pkg::REG_SCALE_FACTOR: prdata = ipr_pkg::DATA_W'(r_cfg.scale_factor);
            default:                   prdata = '0;
        endcase
    end

    // front: accept and classify
    ipr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_restart (restart),
        .i_pix     (i_pix),
        .i_q_stat  (q_stat),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    // request queue
    ipr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // back: write sequencer
    ipr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_wr     (o_wr)
    );

endmodule

@@ design/ipr_front.sv @@
module ipr_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ipr_pkg::t_cfg         i_cfg,
    input  logic                  i_restart,
    ipr_in_if.sink                i_pix,
    input  ipr_pkg::t_q_stat      i_q_stat,
    output logic                  o_push,
    output ipr_pkg::t_entry       o_entry
);

    logic [ipr_pkg::COORD_BITS-1:0] r_col;
    logic [ipr_pkg::COORD_BITS-1:0] r_row;
    logic                           r_s1_valid;
    logic [ipr_pkg::PIX_W-1:0]      r_s1_pixel;
    logic [ipr_pkg::LINE_W-1:0]     r_s1_line;
    logic [ipr_pkg::XB_W-1:0]       r_s1_xbase;
    logic                           r_s1_last;

    logic [ipr_pkg::FACTOR_W-1:0]   f;
    logic [ipr_pkg::EXT_W-1:0]      w;
    logic [ipr_pkg::EXT_W-1:0]      h;
    logic                           last_col;
    logic                           last_row;
    logic [ipr_pkg::SUM_W-1:0]      x_sum;
    logic [ipr_pkg::SUM_W-1:0]      y_sum;
    logic [ipr_pkg::XB_W-1:0]       xbase;
    logic [ipr_pkg::LINE_W-1:0]     line;
    logic                           ready;
    logic                           accept;

    // position of the incoming pixel within the rectangle
    always_comb begin
        f        = ipr_pkg::eff_factor(i_cfg.scale_factor);
        w        = ipr_pkg::eff_extent(i_cfg.rect_width);
        h        = ipr_pkg::eff_extent(i_cfg.rect_height);
        last_col = (ipr_pkg::EXT_W'(r_col) + ipr_pkg::EXT_W'(1)) >= w;
        last_row = (ipr_pkg::EXT_W'(r_row) + ipr_pkg::EXT_W'(1)) >= h;
        x_sum    = ipr_pkg::SUM_W'(i_cfg.origin_x) + ipr_pkg::SUM_W'(r_col);
        y_sum    = ipr_pkg::SUM_W'(i_cfg.origin_y) + ipr_pkg::SUM_W'(r_row);
        xbase    = ipr_pkg::XB_W'(x_sum) * ipr_pkg::XB_W'(f);
        line     = ipr_pkg::LINE_W'(y_sum) * ipr_pkg::LINE_W'(f);
    end

    // handshake: the stage frees up when the queue takes its request
    assign ready       = !r_s1_valid || !i_q_stat.full;
    assign accept      = i_pix.valid && ready;
    assign o_push      = r_s1_valid && !i_q_stat.full;
    assign i_pix.ready = ready;

    // line address of the row, multiplied on the way into the queue
    always_comb begin
        o_entry.pixel    = r_s1_pixel;
        o_entry.row_base = ipr_pkg::ADDR_W'(ipr_pkg::PROD_W'(r_s1_line)
                                            * ipr_pkg::PROD_W'(i_cfg.dest_pitch));
        o_entry.xbase    = r_s1_xbase;
        o_entry.last_pix = r_s1_last;
    end

    // column and row counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // classification stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (o_push) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pixel <= i_pix.pixel_in;
            r_s1_line  <= line;
            r_s1_xbase <= xbase;
            r_s1_last  <= last_col && last_row;
        end
    end

endmodule

@@ design/ipr_fifo.sv @@
module ipr_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ipr_pkg::t_entry       i_entry,
    input  logic                  i_pop,
    output ipr_pkg::t_entry       o_head,
    output ipr_pkg::t_q_stat      o_stat
);

    ipr_pkg::t_entry              r_mem [ipr_pkg::QDEPTH];
    logic [ipr_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [ipr_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [ipr_pkg::QPTR_W:0]     r_count;

    // status and head of queue
    assign o_stat.full  = r_count == (ipr_pkg::QPTR_W + 1)'(ipr_pkg::QDEPTH);
    assign o_stat.empty = r_count == '0;
    assign o_head       = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == ipr_pkg::QPTR_W'(ipr_pkg::QDEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == ipr_pkg::QPTR_W'(ipr_pkg::QDEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // queue sanity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (ipr_pkg::QPTR_W + 1)'(ipr_pkg::QDEPTH))
        else $error("queue fill level beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full))
        else $error("request pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("request popped from empty queue");

endmodule

@@ design/ipr_back.sv @@
module ipr_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ipr_pkg::t_cfg         i_cfg,
    input  ipr_pkg::t_entry       i_head,
    input  ipr_pkg::t_q_stat      i_q_stat,
    output logic                  o_pop,
    ipr_out_if.source             o_wr
);

    logic [ipr_pkg::FACTOR_W-1:0] r_dx;
    logic [ipr_pkg::FACTOR_W-1:0] r_dy;
    logic [ipr_pkg::ADDR_W-1:0]   r_dy_off;
    logic                         r_valid;
    logic [ipr_pkg::ADDR_W-1:0]   r_addr;
    logic [ipr_pkg::PIX_W-1:0]    r_value;
    logic                         r_block_last;
    logic                         r_rect_done;

    logic [ipr_pkg::FACTOR_W-1:0] f;
    logic [ipr_pkg::FACTOR_W-1:0] f_last;
    logic                         load;
    logic                         dx_end;
    logic                         dy_end;
    logic                         fin;
    logic [ipr_pkg::ADDR_W-1:0]   addr;

    // one write per cycle from the head request while the receiver is ready
    always_comb begin
        f      = ipr_pkg::eff_factor(i_cfg.scale_factor);
        f_last = f - 1'b1;
        load   = !i_q_stat.empty && (!r_valid || o_wr.ready);
        dx_end = r_dx == f_last;
        dy_end = r_dy == f_last;
        fin    = dx_end && dy_end;
        addr   = i_head.row_base + r_dy_off + ipr_pkg::ADDR_W'(i_head.xbase)
                 + ipr_pkg::ADDR_W'(r_dx);
    end

    assign o_pop = load && fin;

    // sub-pixel counters, dy outer and dx inner
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dx     <= '0;
            r_dy     <= '0;
            r_dy_off <= '0;
        end else if (load) begin
            if (dx_end) begin
                r_dx <= '0;
                if (dy_end) begin
                    r_dy     <= '0;
                    r_dy_off <= '0;
                end else begin
                    r_dy     <= r_dy + 1'b1;
                    r_dy_off <= r_dy_off + ipr_pkg::ADDR_W'(i_cfg.dest_pitch);
                end
            end else begin
                r_dx <= r_dx + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_wr.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_addr       <= addr;
            r_value      <= i_head.pixel;
            r_block_last <= fin;
            r_rect_done  <= fin && i_head.last_pix;
        end
    end

    assign o_wr.valid         = r_valid;
    assign o_wr.write_address = r_addr;
    assign o_wr.write_value   = r_value;
    assign o_wr.block_last    = r_block_last;
    assign o_wr.rect_done     = r_rect_done;

    // write sequencing checks
    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_rect_done) |-> r_block_last)
        else $error("rectangle end flagged on a non-final write");

    a_pop_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_valid && r_block_last))
        else $error("request retired without its final write");

    a_rise_from_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> $past(!i_q_stat.empty))
        else $error("write produced with no queued request");

endmodule

@@ verif/integer_pixel_replication_scaler_tb.sv @@
`timescale 1ns / 100ps

module integer_pixel_replication_scaler_tb;
    import ipr_pkg::*;

    localparam int CLK_PERIOD       = 4;
    localparam int RESET_CYCLES     = 11;
    localparam int HOLD_CYCLES      = 300;
    localparam int SETTLE_CYCLES    = 6;
    localparam int RANDOM_PER_PHASE = 22;
    localparam int MAX_REPORTS      = 60;
    localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_IDX_W'(NUM_REGS);

    // one expected destination write
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  value;
        logic              block_last;
        logic              rect_done;
    } write_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    ipr_in_if  pix_if ();
    ipr_out_if wr_if ();

    integer_pixel_replication_scaler uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_wr    (wr_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // scaler state as predicted
    t_cfg        cfg;
    int unsigned col_pos;
    int unsigned row_pos;

    write_t           expected_writes[$];
    logic [PIX_W-1:0] pending_pixels[$];
    int unsigned      send_idle_pct = 0;
    int unsigned      stall_pct = 0;
    logic             rx_hold = 1'b0;
    bit               hold_armed = 1'b0;
    int               mismatch_count = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(2_000_000);
        $display("** integer_pixel_replication_scaler: FAILED **");
        $finish;
    end

    // long receiver hold-off, counted here once armed
    initial begin
        wait (hold_armed);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // zero acts as one, above the coordinate range clamps to it
    function automatic int unsigned clamp_extent(input logic [DIM_W-1:0] v);
        int unsigned lim;
        lim = 1 << COORD_BITS;
        if (v == '0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    // factor x factor writes for one source pixel, then advance the raster position
    function automatic void predict_pixel_writes(input logic [PIX_W-1:0] pix);
        int unsigned     f;
        int unsigned     w;
        int unsigned     h;
        bit              last_col;
        bit              last_pix;
        longint unsigned addr;
        write_t          wr;
        if (cfg.scale_factor == '0) begin
            f = 1;
        end else if (cfg.scale_factor > MAX_FACTOR) begin
            f = MAX_FACTOR;
        end else begin
            f = cfg.scale_factor;
        end
        w = clamp_extent(cfg.rect_width);
        h = clamp_extent(cfg.rect_height);
        last_col = (col_pos + 1 >= w);
        last_pix = last_col && (row_pos + 1 >= h);
        for (int unsigned dy = 0; dy < f; dy++) begin
            for (int unsigned dx = 0; dx < f; dx++) begin
                addr = ((64'(cfg.origin_y) + row_pos) * f + dy) * 64'(cfg.dest_pitch)
                     + (64'(cfg.origin_x) + col_pos) * f + dx;
                wr.addr       = addr[ADDR_W-1:0];
                wr.value      = pix;
                wr.block_last = (dy + 1 == f) && (dx + 1 == f);
                wr.rect_done  = wr.block_last && last_pix;
                expected_writes.push_back(wr);
            end
        end
        if (last_col) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endfunction

    // register write as seen by the scaler; any known register restarts the rectangle
    function automatic void apply_register(input logic [REG_IDX_W-1:0] idx,
                                           input logic [DATA_W-1:0] value);
        case (idx)
            REG_ORIGIN_X:     cfg.origin_x     = value[ORG_W-1:0];
            REG_ORIGIN_Y:     cfg.origin_y     = value[ORG_W-1:0];
            REG_RECT_WIDTH:   cfg.rect_width   = value[DIM_W-1:0];
            REG_RECT_HEIGHT:  cfg.rect_height  = value[DIM_W-1:0];
            REG_DEST_PITCH:   cfg.dest_pitch   = value[PITCH_W-1:0];
            REG_SCALE_FACTOR: cfg.scale_factor = value[SCALE_W-1:0];
            default: return;
        endcase
        col_pos = 0;
        row_pos = 0;
    endfunction

    // apb write: setup cycle, then access until pready
    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        apply_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned rx_pct);
        @(negedge i_clk);
        send_idle_pct = send_pct;
        stall_pct     = rx_pct;
    endtask

    task automatic queue_random_pixels(input int n);
        @(negedge i_clk);
        repeat (n) pending_pixels.push_back(PIX_W'($urandom_range(0, 255)));
    endtask

    // wait for every pixel request to go in and every write to come out
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_pixels.size() != 0 || pix_if.valid || expected_writes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // random rectangle, mostly small with small factors
    task automatic random_setup();
        int unsigned sel;
        write_register(REG_ORIGIN_X, $urandom_range(0, 4095));
        write_register(REG_ORIGIN_Y, $urandom_range(0, 4095));
        sel = $urandom_range(19);
        write_register(REG_RECT_WIDTH, (sel == 0) ? 0 :
                       (sel == 1) ? $urandom_range(4097, 8191) : $urandom_range(1, 5));
        write_register(REG_RECT_HEIGHT, ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4));
        write_register(REG_DEST_PITCH, $urandom_range(0, 65535));
        write_register(REG_SCALE_FACTOR,
                       ($urandom_range(9) < 7) ? $urandom_range(1, 3) : $urandom_range(0, 15));
    endtask

    // pixel request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else begin
            if (pix_if.valid && pix_if.ready) begin
                predict_pixel_writes(pix_if.pixel_in);
            end
            if (!pix_if.valid || pix_if.ready) begin
                if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    pix_if.valid    <= 1'b1;
                    pix_if.pixel_in <= pending_pixels.pop_front();
                end else begin
                    pix_if.valid <= 1'b0;
                end
            end
        end
    end

    // write monitor and receiver stalls
    always @(posedge i_clk) begin
        write_t want;
        if (!i_rst_n) begin
            wr_if.ready <= 1'b0;
        end else begin
            if (wr_if.valid && wr_if.ready) begin
                if (expected_writes.size() == 0) begin
                    report_mismatch($sformatf("unexpected write addr %h value %h last %b done %b",
                                              wr_if.write_address, wr_if.write_value,
                                              wr_if.block_last, wr_if.rect_done));
                end else begin
                    want = expected_writes.pop_front();
                    if (wr_if.write_address !== want.addr || wr_if.write_value !== want.value
                        || wr_if.block_last !== want.block_last
                        || wr_if.rect_done !== want.rect_done) begin
                        report_mismatch($sformatf(
                            "addr %h/%h value %h/%h last %b/%b done %b/%b (got/exp)",
                            wr_if.write_address, want.addr, wr_if.write_value, want.value,
                            wr_if.block_last, want.block_last,
                            wr_if.rect_done, want.rect_done));
                    end
                end
            end
            wr_if.ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
        end
    end

    // stimulus
    initial begin
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        pix_if.valid    = 1'b0;
        pix_if.pixel_in = '0;
        wr_if.ready     = 1'b0;
        cfg = '{origin_x: '0, origin_y: '0, rect_width: DIM_W'(1), rect_height: DIM_W'(1),
                dest_pitch: PITCH_W'(1), scale_factor: SCALE_W'(2)};
        col_pos = 0;
        row_pos = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: factor two, one-pixel rectangle
        @(negedge i_clk);
        pending_pixels = '{8'h00, 8'hff, 8'h55, 8'haa};
        wait_drained();

        // largest factor, origins and pitch at the top so addresses wrap
        write_register(REG_ORIGIN_X, 4095);
        write_register(REG_ORIGIN_Y, 4095);
        write_register(REG_RECT_WIDTH, 3);
        write_register(REG_RECT_HEIGHT, 2);
        write_register(REG_DEST_PITCH, 65535);
        write_register(REG_SCALE_FACTOR, 8);
        @(negedge i_clk);
        pending_pixels = '{8'h01, 8'h80, 8'h7f, 8'hfe, 8'h10, 8'h20, 8'h33};
        wait_drained();

        // zero factor, zero extents and zero pitch
        write_register(REG_SCALE_FACTOR, 0);
        write_register(REG_RECT_WIDTH, 0);
        write_register(REG_RECT_HEIGHT, 0);
        write_register(REG_DEST_PITCH, 0);
        write_register(REG_ORIGIN_X, 0);
        write_register(REG_ORIGIN_Y, 0);
        @(negedge i_clk);
        pending_pixels = '{8'h11, 8'h22, 8'h44};
        wait_drained();

        // factor above the limit clamps
        write_register(REG_SCALE_FACTOR, 15);
        write_register(REG_RECT_WIDTH, 2);
        write_register(REG_RECT_HEIGHT, 2);
        @(negedge i_clk);
        pending_pixels = '{8'h99, 8'h66, 8'hc3, 8'h3c};
        wait_drained();

        // oversized extents clamp; a write past the last register changes nothing
        write_register(REG_RECT_WIDTH, 8191);
        write_register(REG_RECT_HEIGHT, 4097);
        write_register(REG_SCALE_FACTOR, 1);
        write_register(REG_DEST_PITCH, 32768);
        write_register(REG_ORIGIN_X, 2048);
        write_register(REG_ORIGIN_Y, 1);
        @(negedge i_clk);
        pending_pixels = '{8'h5a, 8'ha5};
        wait_drained();
        write_register(REG_SPARE, 32'hffff_ffff);
        @(negedge i_clk);
        pending_pixels = '{8'he7};
        wait_drained();

        // steady flow with a long receiver hold-off so the queue fills
        random_setup();
        set_idling(0, 0);
        @(negedge i_clk);
        hold_armed = 1'b1;
        queue_random_pixels(RANDOM_PER_PHASE);
        wait_drained();

        // sparse sender
        random_setup();
        set_idling(81, 0);
        queue_random_pixels(RANDOM_PER_PHASE);
        wait_drained();

        // slow receiver, sender pausing halfway until all writes are out
        random_setup();
        set_idling(0, 81);
        queue_random_pixels(RANDOM_PER_PHASE / 2);
        wait_drained();
        queue_random_pixels(RANDOM_PER_PHASE / 2);
        wait_drained();

        // light gaps on both sides
        random_setup();
        set_idling(12, 12);
        queue_random_pixels(RANDOM_PER_PHASE);
        wait_drained();

        if (mismatch_count == 0) begin
            $display("** integer_pixel_replication_scaler: PASSED **");
        end else begin
            $display("** integer_pixel_replication_scaler: FAILED **");
        end
        $finish;
    end

endmodule
